### rtl/lru_handle_table_macros.svh
// ----------------------------------------------------------------------------
// lru_handle_table assertion macros
// Shorthand for clocked assertions with a synchronous reset guard.
// ----------------------------------------------------------------------------
`ifndef LRU_HANDLE_TABLE_MACROS_SVH
`define LRU_HANDLE_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LRUHT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LRUHT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lruht_pkg.sv
// ----------------------------------------------------------------------------
// lruht_pkg
// Types and constants shared by the handle table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lruht_pkg;

  localparam int TABLE_ENTRIES_DEF = 8;
  localparam int KEY_W             = 32;
  localparam int SLOT_W            = 3;

  typedef enum logic {
    OP_GET   = 1'b0,
    OP_CLOSE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_OPEN_FAIL    = 2'd1,
    ST_CLOSE_ABSENT = 2'd2
  } status_t;

  typedef struct packed {
    op_t              operation;
    logic [KEY_W-1:0] key;
    logic             open_ok;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
    status_t           status;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/lruht_lookup.sv
// ----------------------------------------------------------------------------
// lruht_lookup
// Parallel key match, victim select and free slot search over all entries.
// ----------------------------------------------------------------------------
`default_nettype none

module lruht_lookup
  import lruht_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int IDX_W = $clog2(TABLE_ENTRIES),
  localparam int AGE_W = IDX_W
) (
  input  logic [KEY_W-1:0]         key,
  input  logic [KEY_W-1:0]         entry_key   [TABLE_ENTRIES],
  input  logic [TABLE_ENTRIES-1:0] entry_valid,
  input  logic [AGE_W-1:0]         entry_age   [TABLE_ENTRIES],
  output logic                     hit,
  output logic [TABLE_ENTRIES-1:0] hit_sel,
  output logic [IDX_W-1:0]         hit_idx,
  output logic [AGE_W-1:0]         hit_age,
  output logic                     full,
  output logic [TABLE_ENTRIES-1:0] victim_sel,
  output logic [KEY_W-1:0]         victim_key,
  output logic [TABLE_ENTRIES-1:0] free_sel,
  output logic [IDX_W-1:0]         free_idx
);

  localparam logic [AGE_W-1:0] OLDEST_AGE = AGE_W'(TABLE_ENTRIES - 1);

  logic [IDX_W-1:0] victim_idx;

  // Valid keys are distinct, so at most one entry matches; when the table is
  // full the ages are distinct, so exactly one entry holds the oldest age.
  always_comb begin
    hit_sel    = '0;
    hit_idx    = '0;
    hit_age    = '0;
    victim_sel = '0;
    victim_idx = '0;
    victim_key = '0;
    free_sel   = '0;
    free_idx   = '0;
    full       = &entry_valid;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (entry_valid[i] && entry_key[i] == key) begin
        hit_sel[i] = 1'b1;
        hit_idx    = hit_idx | IDX_W'(i);
        hit_age    = hit_age | entry_age[i];
      end
      if (entry_valid[i] && entry_age[i] == OLDEST_AGE) begin
        victim_sel[i] = 1'b1;
        victim_idx    = victim_idx | IDX_W'(i);
        victim_key    = victim_key | entry_key[i];
      end
    end
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        free_sel    = '0;
        free_sel[i] = 1'b1;
        free_idx    = IDX_W'(i);
      end
    end
    if (full) begin
      free_sel = victim_sel;
      free_idx = victim_idx;
    end
  end

  assign hit = |hit_sel;

endmodule

`default_nettype wire

### rtl/lruht_store.sv
// ----------------------------------------------------------------------------
// lruht_store
// Entry keys, valid bits and recency ranks, with their update for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module lruht_store
  import lruht_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int AGE_W = $clog2(TABLE_ENTRIES)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     update,
  input  op_t                      operation,
  input  logic [KEY_W-1:0]         key,
  input  logic                     open_ok,
  input  logic                     hit,
  input  logic [TABLE_ENTRIES-1:0] hit_sel,
  input  logic [AGE_W-1:0]         hit_age,
  input  logic                     full,
  input  logic [TABLE_ENTRIES-1:0] victim_sel,
  input  logic [TABLE_ENTRIES-1:0] free_sel,
  output logic [KEY_W-1:0]         entry_key   [TABLE_ENTRIES],
  output logic [TABLE_ENTRIES-1:0] entry_valid,
  output logic [AGE_W-1:0]         entry_age   [TABLE_ENTRIES]
);

  logic [KEY_W-1:0]         entry_key_next [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] entry_valid_next;
  logic [AGE_W-1:0]         entry_age_next [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] keep;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      entry_key_next[i]   = entry_key[i];
      entry_valid_next[i] = entry_valid[i];
      entry_age_next[i]   = entry_age[i];
      keep[i]             = entry_valid[i] && !(full && victim_sel[i]);
      if (operation == OP_CLOSE) begin
        if (hit) begin
          if (hit_sel[i]) begin
            entry_valid_next[i] = 1'b0;
            entry_age_next[i]   = '0;
          end else if (entry_valid[i] && entry_age[i] > hit_age) begin
            entry_age_next[i] = entry_age[i] - AGE_W'(1);
          end
        end
      end else if (hit) begin
        if (hit_sel[i]) begin
          entry_age_next[i] = '0;
        end else if (entry_valid[i] && entry_age[i] < hit_age) begin
          entry_age_next[i] = entry_age[i] + AGE_W'(1);
        end
      end else begin
        entry_valid_next[i] = keep[i];
        if (!keep[i]) begin
          entry_age_next[i] = '0;
        end
        if (open_ok) begin
          if (free_sel[i]) begin
            entry_key_next[i]   = key;
            entry_valid_next[i] = 1'b1;
            entry_age_next[i]   = '0;
          end else if (keep[i]) begin
            entry_age_next[i] = entry_age[i] + AGE_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        entry_age[i] <= '0;
      end
    end else if (update) begin
      entry_valid <= entry_valid_next;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        entry_age[i] <= entry_age_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        entry_key[i] <= entry_key_next[i];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/lru_handle_table.sv
// ----------------------------------------------------------------------------
// lru_handle_table
// Fully associative least-recently-used table of open handles.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. busy is
// never raised, so one request may be issued in every cycle.
// Each request carries an operation (get or close), a 32-bit key and an
// open_ok flag used on a get miss. A get hit makes the key most recent; a get
// miss evicts the least recent entry when the table is full and then inserts
// the key if open_ok is set. A close removes the key if present.
// The request is registered, looked up against all entries combinationally,
// and the response is registered: done pulses for one cycle, with the
// response on result. The table update lands on the same edge as the
// response, so the following request sees it.
// Throughput is one request per cycle, with the key compared against every entry in parallel.
// The receiver cannot hold off responses; each is valid for exactly one cycle.
// Reset empties the table and drops any request in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_handle_table
  import lruht_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output rsp_t result
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int AGE_W = IDX_W;

  logic                     req_valid;
  req_t                     req;
  rsp_t                     result_next;

  logic [KEY_W-1:0]         entry_key   [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [AGE_W-1:0]         entry_age   [TABLE_ENTRIES];

  logic                     hit;
  logic [TABLE_ENTRIES-1:0] hit_sel;
  logic [IDX_W-1:0]         hit_idx;
  logic [AGE_W-1:0]         hit_age;
  logic                     full;
  logic [TABLE_ENTRIES-1:0] victim_sel;
  logic [KEY_W-1:0]         victim_key;
  logic [TABLE_ENTRIES-1:0] free_sel;
  logic [IDX_W-1:0]         free_idx;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req <= request;
    end
  end

  lruht_lookup #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_lookup (
    .key        (req.key),
    .entry_key  (entry_key),
    .entry_valid(entry_valid),
    .entry_age  (entry_age),
    .hit        (hit),
    .hit_sel    (hit_sel),
    .hit_idx    (hit_idx),
    .hit_age    (hit_age),
    .full       (full),
    .victim_sel (victim_sel),
    .victim_key (victim_key),
    .free_sel   (free_sel),
    .free_idx   (free_idx)
  );

  lruht_store #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .update     (req_valid),
    .operation  (req.operation),
    .key        (req.key),
    .open_ok    (req.open_ok),
    .hit        (hit),
    .hit_sel    (hit_sel),
    .hit_age    (hit_age),
    .full       (full),
    .victim_sel (victim_sel),
    .free_sel   (free_sel),
    .entry_key  (entry_key),
    .entry_valid(entry_valid),
    .entry_age  (entry_age)
  );

  always_comb begin
    result_next             = '0;
    result_next.hit         = hit;
    result_next.status      = ST_OK;
    if (hit) begin
      result_next.slot = SLOT_W'(hit_idx);
    end else if (req.operation == OP_CLOSE) begin
      result_next.status = ST_CLOSE_ABSENT;
    end else begin
      result_next.slot        = SLOT_W'(free_idx);
      result_next.evicted     = full;
      result_next.evicted_key = full ? victim_key : '0;
      if (!req.open_ok) begin
        result_next.status = ST_OPEN_FAIL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

### rtl/lruht_checker.sv
// ----------------------------------------------------------------------------
// lruht_checker
// Port-level checks on request timing and response consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_handle_table_macros.svh"

module lruht_checker
  import lruht_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire req_t request,
  input wire logic done,
  input wire rsp_t result
);

  `LRUHT_ASSERT_NXT(a_resp_follows, start && !busy, ##1 done, "response missing for request")
  `LRUHT_ASSERT_IMP(a_no_spurious, done, $past(start && !busy && !rst, 2), "response without request")
  `LRUHT_ASSERT_IMP(a_hit_clean, done && result.hit, result.status == ST_OK && !result.evicted && result.evicted_key == '0, "hit response carries eviction or error")
  `LRUHT_ASSERT_IMP(a_absent_zero, done && result.status == ST_CLOSE_ABSENT, !result.hit && result.slot == '0 && !result.evicted && result.evicted_key == '0, "close of absent key reports fields")

endmodule

bind lru_handle_table lruht_checker u_lruht_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .request(request),
  .done   (done),
  .result (result)
);

`default_nettype wire
